// ----- src/idt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idt_pkg
// Shared types and constants of the indent/dedent token generator.
// ----------------------------------------------------------------------------
package idt_pkg;

    // Field widths of the stream payloads
    localparam int TYPE_W      = 16;
    localparam int TAG_W       = 16;
    localparam int IN_WIDTH_W  = 8;
    localparam int IN_TDATA_W  = 40;
    localparam int IN_TUSER_W  = 1;
    localparam int OUT_TDATA_W = 32;
    localparam int OUT_TUSER_W = 3;

    // Configuration port
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    // Register indexes (byte address divided by four)
    localparam logic [1:0] REG_NEWLINE_TYPE = 2'd0;
    localparam logic [1:0] REG_INDENT_TYPE  = 2'd1;
    localparam logic [1:0] REG_DEDENT_TYPE  = 2'd2;

    // Register reset values
    localparam logic [TYPE_W-1:0] RST_NEWLINE_TYPE = 16'd0;
    localparam logic [TYPE_W-1:0] RST_INDENT_TYPE  = 16'd1;
    localparam logic [TYPE_W-1:0] RST_DEDENT_TYPE  = 16'd2;

    typedef struct packed {
        logic [TYPE_W-1:0] newline_type;
        logic [TYPE_W-1:0] indent_type;
        logic [TYPE_W-1:0] dedent_type;
    } t_cfg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INDENT,
        S_DEDENT,
        S_DWAIT,
        S_FLUSH,
        S_FEND
    } t_state;

    // Source of a result loaded into the output register
    typedef enum logic [1:0] {
        EM_TOKEN_IN,
        EM_TOKEN_HELD,
        EM_INDENT,
        EM_DEDENT
    } t_emit;

    typedef struct packed {
        logic  accept;
        logic  emit;
        t_emit src;
        logic  last;
        logic  ovf;
        logic  push;
        logic  pop;
        logic  set_flushed;
    } t_cmd;

    typedef struct packed {
        logic slot_free;
        logic in_eoi;
        logic in_nl;
        logic in_gt;
        logic in_lt;
        logic lvl_gt1;
        logic lvl_eq2;
        logic lvl_full;
        logic flushed;
        logic more;
    } t_status;

endpackage

// ----- src/indent_dedent_token_generator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indent_dedent_token_generator
// Inserts INDENT and DEDENT tokens into a lexer token stream by the
// offside rule, using a stack of indentation widths.
// ----------------------------------------------------------------------------
// Tokens are handled one at a time. An ordinary token, an end token with
// nothing to flush, or a newline that neither indents nor dedents gives one
// result. A newline that indents gives the newline, then INDENT if the
// stack has room. One that closes k levels gives the newline, then k
// DEDENTs; each further DEDENT waits in S_DWAIT for the registered read of
// the width stack memory. The first end-of-input token flushes one DEDENT
// per open level at one per cycle when the output is free, then passes the
// end token. Results leave through an output register, so a new token is
// taken while the last result is consumed. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module indent_dedent_token_generator #(
    parameter int STACK_DEPTH = 32,
    parameter int WIDTH_BITS  = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side: tdata = {token_type[15:0], token_tag[31:16], indent_width[39:32]}
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,
    // tuser = {end_of_input[0]}
    input  logic [0:0]  i_s_tuser,
    // master side: tdata = {out_type[15:0], out_tag[31:16]}
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,
    output logic        o_m_tlast,
    // tuser = {generated[0], out_end[1], overflow[2]}
    output logic [2:0]  o_m_tuser,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import idt_pkg::*;

    t_cfg    cfg;
    t_cmd    cmd;
    t_status status;

    idt_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    idt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    idt_dpath #(
        .STACK_DEPTH (STACK_DEPTH),
        .WIDTH_BITS  (WIDTH_BITS)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser),
        .i_cfg      (cfg),
        .i_cmd      (cmd),
        .o_status   (status)
    );

`ifndef SYNTHESIS
    // Take a token only when the output register can accept a result
    a_ready_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> (!o_m_tvalid || i_m_tready))
        else $error("token taken while output register is blocked");

    // Overflow only on a passed newline that closes its transaction group
    a_ovf_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[2]) |-> (o_m_tlast && !o_m_tuser[0]))
        else $error("overflow flag on a generated or non-final result");

    // A pushed level always starts a pending INDENT
    a_push_indent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.push |=> (o_m_tvalid && !o_m_tlast && !o_s_tready))
        else $error("push without a following INDENT");

    // Reset empties the output register
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");
`endif

endmodule

// ----- src/idt_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idt_regs
// Configuration registers behind an APB-style port: newline, indent and
// dedent type codes.
// ----------------------------------------------------------------------------
module idt_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [idt_pkg::APB_AW-1:0] paddr,
    input  logic [idt_pkg::APB_DW-1:0] pwdata,
    output logic [idt_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    output idt_pkg::t_cfg              o_cfg
);
    import idt_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    // Write registers on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.newline_type <= RST_NEWLINE_TYPE;
            r_cfg.indent_type  <= RST_INDENT_TYPE;
            r_cfg.dedent_type  <= RST_DEDENT_TYPE;
        end else if (wr_en) begin
            case (reg_idx)
                REG_NEWLINE_TYPE: r_cfg.newline_type <= pwdata[TYPE_W-1:0];
                REG_INDENT_TYPE:  r_cfg.indent_type  <= pwdata[TYPE_W-1:0];
                REG_DEDENT_TYPE:  r_cfg.dedent_type  <= pwdata[TYPE_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        case (reg_idx)
            REG_NEWLINE_TYPE: prdata = APB_DW'(r_cfg.newline_type);
            REG_INDENT_TYPE:  prdata = APB_DW'(r_cfg.indent_type);
            REG_DEDENT_TYPE:  prdata = APB_DW'(r_cfg.dedent_type);
            default:          prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ----- src/idt_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idt_ctrl
// Sequencer: decides per token what to emit and steps through indent,
// dedent and end-of-input flush sequences.
// ----------------------------------------------------------------------------
module idt_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  idt_pkg::t_status i_status,
    output idt_pkg::t_cmd    o_cmd
);
    import idt_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state           = r_state;
        o_cmd             = '0;
        o_cmd.src         = EM_TOKEN_IN;
        o_s_tready        = (r_state == S_IDLE) && i_status.slot_free;

        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid && o_s_tready) begin
                    o_cmd.accept = 1'b1;
                    priority if (i_status.in_eoi) begin
                        o_cmd.set_flushed = 1'b1;
                        if (!i_status.flushed && i_status.lvl_gt1) begin
                            n_state = S_FLUSH;
                        end else begin
                            o_cmd.emit = 1'b1;
                            o_cmd.last = 1'b1;
                        end
                    end else if (!i_status.in_nl) begin
                        o_cmd.emit = 1'b1;
                        o_cmd.last = 1'b1;
                    end else if (i_status.in_gt) begin
                        o_cmd.emit = 1'b1;
                        if (!i_status.lvl_full) begin
                            o_cmd.push = 1'b1;
                            n_state    = S_INDENT;
                        end else begin
                            o_cmd.ovf  = 1'b1;
                            o_cmd.last = 1'b1;
                        end
                    end else begin
                        o_cmd.emit = 1'b1;
                        if (i_status.lvl_gt1 && i_status.in_lt) begin
                            n_state = S_DEDENT;
                        end else begin
                            o_cmd.last = 1'b1;
                        end
                    end
                end
            end
            S_INDENT: begin
                if (i_status.slot_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.src  = EM_INDENT;
                    o_cmd.last = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_DEDENT: begin
                if (i_status.slot_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.src  = EM_DEDENT;
                    o_cmd.pop  = 1'b1;
                    o_cmd.last = !i_status.more;
                    n_state    = i_status.more ? S_DWAIT : S_IDLE;
                end
            end
            S_DWAIT: begin
                // let the stack read settle on the new level
                n_state = S_DEDENT;
            end
            S_FLUSH: begin
                if (i_status.slot_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.src  = EM_DEDENT;
                    o_cmd.pop  = 1'b1;
                    if (i_status.lvl_eq2) begin
                        n_state = S_FEND;
                    end
                end
            end
            S_FEND: begin
                if (i_status.slot_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.src  = EM_TOKEN_HELD;
                    o_cmd.last = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- src/idt_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idt_dpath
// Datapath: width stack memory, top-of-stack and level registers, held
// token and the output register.
// ----------------------------------------------------------------------------
module idt_dpath #(
    parameter int STACK_DEPTH = 32,
    parameter int WIDTH_BITS  = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [idt_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    input  logic [idt_pkg::IN_TUSER_W-1:0]  i_s_tuser,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [idt_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    output logic                            o_m_tlast,
    output logic [idt_pkg::OUT_TUSER_W-1:0] o_m_tuser,
    input  idt_pkg::t_cfg                   i_cfg,
    input  idt_pkg::t_cmd                   i_cmd,
    output idt_pkg::t_status                o_status
);
    import idt_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int LW = $clog2(STACK_DEPTH + 1);
    localparam int CW = (WIDTH_BITS > IN_WIDTH_W) ? WIDTH_BITS : IN_WIDTH_W;
    localparam logic [CW-1:0] WMAX = CW'((1 << WIDTH_BITS) - 1);

    // Input fields
    logic [TYPE_W-1:0]     in_type;
    logic [TAG_W-1:0]      in_tag;
    logic [IN_WIDTH_W-1:0] in_width;
    logic                  in_eoi;
    logic [CW-1:0]         w_ext;
    logic [WIDTH_BITS-1:0] w_sat;

    assign in_type  = i_s_tdata[15:0];
    assign in_tag   = i_s_tdata[31:16];
    assign in_width = i_s_tdata[39:32];
    assign in_eoi   = i_s_tuser[0];
    assign w_ext    = CW'(in_width);
    assign w_sat    = (w_ext > WMAX) ? WMAX[WIDTH_BITS-1:0] : w_ext[WIDTH_BITS-1:0];

    // Stack state
    logic [WIDTH_BITS-1:0] mem [STACK_DEPTH];
    logic [WIDTH_BITS-1:0] r_rd;
    logic [WIDTH_BITS-1:0] r_top;
    logic [LW-1:0]         r_level;
    logic                  r_flushed;
    logic [AW-1:0]         rd_addr;

    // Held token
    logic [TYPE_W-1:0]     r_type;
    logic [TAG_W-1:0]      r_tag;
    logic                  r_eoi;
    logic [WIDTH_BITS-1:0] r_width;

    assign rd_addr = AW'(r_level - LW'(2));

    // Write pushed widths; read the entry below the top every cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            mem[r_level[AW-1:0]] <= w_sat;
        end
        r_rd <= mem[rd_addr];
    end

    // Level, top of stack and end-of-input flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level   <= LW'(1);
            r_top     <= '0;
            r_flushed <= 1'b0;
        end else begin
            if (i_cmd.push) begin
                r_level <= r_level + LW'(1);
                r_top   <= w_sat;
            end else if (i_cmd.pop) begin
                r_level <= r_level - LW'(1);
                r_top   <= (r_level == LW'(2)) ? '0 : r_rd;
            end
            if (i_cmd.set_flushed) begin
                r_flushed <= 1'b1;
            end
        end
    end

    // Hold the accepted token
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_type  <= in_type;
            r_tag   <= in_tag;
            r_eoi   <= in_eoi;
            r_width <= w_sat;
        end
    end

    // Output register
    logic r_ovalid;
    logic [TYPE_W-1:0] r_otype;
    logic [TAG_W-1:0]  r_otag;
    logic r_ogen, r_oend, r_oovf, r_olast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ovalid <= 1'b1;
        end else if (i_m_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_olast <= i_cmd.last;
            r_oovf  <= i_cmd.ovf;
            unique case (i_cmd.src)
                EM_TOKEN_IN: begin
                    r_otype <= in_type;
                    r_otag  <= in_tag;
                    r_ogen  <= 1'b0;
                    r_oend  <= in_eoi;
                end
                EM_TOKEN_HELD: begin
                    r_otype <= r_type;
                    r_otag  <= r_tag;
                    r_ogen  <= 1'b0;
                    r_oend  <= r_eoi;
                end
                EM_INDENT: begin
                    r_otype <= i_cfg.indent_type;
                    r_otag  <= '0;
                    r_ogen  <= 1'b1;
                    r_oend  <= 1'b0;
                end
                EM_DEDENT: begin
                    r_otype <= i_cfg.dedent_type;
                    r_otag  <= '0;
                    r_ogen  <= 1'b1;
                    r_oend  <= 1'b0;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {r_otag, r_otype};
    assign o_m_tlast  = r_olast;
    assign o_m_tuser  = {r_oovf, r_oend, r_ogen};

    // Status toward the sequencer
    assign o_status.slot_free = !r_ovalid || i_m_tready;
    assign o_status.in_eoi    = in_eoi;
    assign o_status.in_nl     = (in_type == i_cfg.newline_type);
    assign o_status.in_gt     = (w_sat > r_top);
    assign o_status.in_lt     = (w_sat < r_top);
    assign o_status.lvl_gt1   = (r_level > LW'(1));
    assign o_status.lvl_eq2   = (r_level == LW'(2));
    assign o_status.lvl_full  = (r_level == LW'(STACK_DEPTH));
    assign o_status.flushed   = r_flushed;
    assign o_status.more      = (r_level > LW'(2)) && (r_width < r_rd);

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the indent/dedent token generator. A queue of
// lexer tokens feeds a stream driver; every accepted token runs through an
// offside-rule predictor that keeps its own width stack and type registers,
// and the monitor compares each result transaction, field by field, with the
// oldest prediction. Both stream sides idle at random, and the type registers
// are rewritten over the APB port between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;
    import idt_pkg::*;

    localparam int STACK_DEPTH = 32;
    localparam int IDLE_LIMIT  = 2000;

    typedef struct packed {
        logic [TYPE_W-1:0]     ttype;
        logic [TAG_W-1:0]      tag;
        logic                  eoi;
        logic [IN_WIDTH_W-1:0] width;
    } t_lex_tok;

    typedef struct packed {
        logic [TYPE_W-1:0] ttype;
        logic [TAG_W-1:0]  tag;
        logic              gen;
        logic              is_end;
        logic              ovf;
        logic              last;
    } t_emit_tok;

    // Block ports
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic o_s_tready;
    logic [39:0] s_tdata = '0;
    logic [0:0] s_tuser = '0;
    logic o_m_tvalid;
    logic m_tready = 1'b0;
    logic [31:0] o_m_tdata;
    logic o_m_tlast;
    logic [2:0] o_m_tuser;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic pready;

    // Stimulus, predictions and scoreboard state
    t_lex_tok  lex_tokens[$];
    t_emit_tok expected_tokens[$];
    t_lex_tok  held_tok;
    bit        tok_held = 1'b0;
    int        send_gap = 0;
    int        recv_stall = 0;
    bit        sender_gaps_on = 1'b1;
    bit        receiver_stalls_on = 1'b1;
    int        mismatch_count = 0;
    int        idle_cycles = 0;
    int        walk_width = 0;
    t_emit_tok seen_tok;
    t_emit_tok want_tok;

    // Predictor state
    t_cfg                  cfg_model = '{RST_NEWLINE_TYPE, RST_INDENT_TYPE, RST_DEDENT_TYPE};
    logic [IN_WIDTH_W-1:0] level_widths[STACK_DEPTH] = '{default: '0};
    int                    depth_used = 1;
    bit                    eof_seen = 1'b0;

    indent_dedent_token_generator #(
        .STACK_DEPTH(STACK_DEPTH),
        .WIDTH_BITS (IN_WIDTH_W)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (s_tdata),
        .i_s_tuser (s_tuser),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(m_tready),
        .o_m_tdata (o_m_tdata),
        .o_m_tlast (o_m_tlast),
        .o_m_tuser (o_m_tuser),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // Clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_emit_tok emit_of(logic [TYPE_W-1:0] ttype, logic [TAG_W-1:0] tag,
                                          logic gen, logic is_end, logic ovf);
        t_emit_tok e;
        e.ttype  = ttype;
        e.tag    = tag;
        e.gen    = gen;
        e.is_end = is_end;
        e.ovf    = ovf;
        e.last   = 1'b0;
        return e;
    endfunction

    // Apply the offside rule to one accepted token and queue its results
    function automatic void offside_predict(t_lex_tok t);
        t_emit_tok outs[$];
        t_emit_tok e;
        if (t.eoi) begin
            // first end token closes every open level
            if (!eof_seen) begin
                eof_seen = 1'b1;
                while (depth_used > 1) begin
                    depth_used--;
                    outs.insert(outs.size(),
                                emit_of(cfg_model.dedent_type, '0, 1'b1, 1'b0, 1'b0));
                end
            end
            outs.insert(outs.size(), emit_of(t.ttype, t.tag, 1'b0, 1'b1, 1'b0));
        end else if (t.ttype != cfg_model.newline_type) begin
            outs.insert(outs.size(), emit_of(t.ttype, t.tag, 1'b0, 1'b0, 1'b0));
        end else if (t.width > level_widths[depth_used-1]) begin
            if (depth_used < STACK_DEPTH) begin
                level_widths[depth_used] = t.width;
                depth_used++;
                outs.insert(outs.size(), emit_of(t.ttype, t.tag, 1'b0, 1'b0, 1'b0));
                outs.insert(outs.size(),
                            emit_of(cfg_model.indent_type, '0, 1'b1, 1'b0, 1'b0));
            end else begin
                // full stack: refuse the push and flag it
                outs.insert(outs.size(), emit_of(t.ttype, t.tag, 1'b0, 1'b0, 1'b1));
            end
        end else begin
            outs.insert(outs.size(), emit_of(t.ttype, t.tag, 1'b0, 1'b0, 1'b0));
            while (depth_used > 1 && t.width < level_widths[depth_used-1]) begin
                depth_used--;
                outs.insert(outs.size(),
                            emit_of(cfg_model.dedent_type, '0, 1'b1, 1'b0, 1'b0));
            end
        end
        foreach (outs[i]) begin
            e = outs[i];
            e.last = (i == outs.size() - 1);
            expected_tokens.insert(expected_tokens.size(), e);
        end
    endfunction

    task automatic note_mismatch(bit unexpected, t_emit_tok want, t_emit_tok got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            if (unexpected)
                $display("[%0t] unexpected token: type=%h tag=%h gen=%b end=%b %s=%b last=%b",
                         $realtime, got.ttype, got.tag, got.gen, got.is_end, "ovf",
                         got.ovf, got.last);
            else
                $display({"[%0t] token mismatch: expected type=%h tag=%h gen=%b end=%b ",
                          "ovf=%b last=%b, got type=%h tag=%h gen=%b end=%b ovf=%b last=%b"},
                         $realtime, want.ttype, want.tag, want.gen, want.is_end, want.ovf,
                         want.last, got.ttype, got.tag, got.gen, got.is_end, got.ovf, got.last);
        end
    endtask

    // Stream driver: present queued tokens, predict on each transaction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && o_s_tready) begin
                offside_predict(held_tok);
                tok_held = 1'b0;
                send_gap = sender_gaps_on ? $urandom_range(0, 8) : 0;
            end
            if (!tok_held) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (lex_tokens.size() != 0) begin
                    held_tok = lex_tokens.pop_front();
                    tok_held = 1'b1;
                    s_tvalid <= 1'b1;
                    s_tdata  <= {held_tok.width, held_tok.tag, held_tok.ttype};
                    s_tuser  <= held_tok.eoi;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compare each transaction with the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && m_tready) begin
                seen_tok.ttype  = o_m_tdata[15:0];
                seen_tok.tag    = o_m_tdata[31:16];
                seen_tok.gen    = o_m_tuser[0];
                seen_tok.is_end = o_m_tuser[1];
                seen_tok.ovf    = o_m_tuser[2];
                seen_tok.last   = o_m_tlast;
                if (expected_tokens.size() == 0) begin
                    note_mismatch(1'b1, seen_tok, seen_tok);
                end else begin
                    want_tok = expected_tokens.pop_front();
                    if (seen_tok !== want_tok)
                        note_mismatch(1'b0, want_tok, seen_tok);
                end
                recv_stall = receiver_stalls_on ? $urandom_range(0, 8) : 0;
            end
            if (recv_stall > 0) begin
                recv_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_tvalid && o_s_tready) || (o_m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    task automatic push_tok(logic [TYPE_W-1:0] ttype, logic [TAG_W-1:0] tag, logic eoi,
                            logic [IN_WIDTH_W-1:0] width);
        t_lex_tok t;
        t.ttype = ttype;
        t.tag   = tag;
        t.eoi   = eoi;
        t.width = width;
        lex_tokens.insert(lex_tokens.size(), t);
    endtask

    // Hold until every token is taken and every result has arrived
    task automatic wait_drained();
        while (lex_tokens.size() != 0 || tok_held || expected_tokens.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic apb_write(logic [1:0] idx, logic [TYPE_W-1:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'h0000, val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_NEWLINE_TYPE: cfg_model.newline_type = val;
            REG_INDENT_TYPE:  cfg_model.indent_type  = val;
            REG_DEDENT_TYPE:  cfg_model.dedent_type  = val;
            default: ;
        endcase
    endtask

    task automatic set_types(logic [TYPE_W-1:0] nl, logic [TYPE_W-1:0] ind,
                             logic [TYPE_W-1:0] ded);
        apb_write(REG_NEWLINE_TYPE, nl);
        apb_write(REG_INDENT_TYPE, ind);
        apb_write(REG_DEDENT_TYPE, ded);
    endtask

    // Open 31 levels of strictly growing width
    task automatic push_full_stack(int base);
        int w;
        w = base;
        repeat (STACK_DEPTH - 1) begin
            w += $urandom_range(1, 7);
            push_tok(cfg_model.newline_type, TAG_W'($urandom), 1'b0, w[7:0]);
        end
    endtask

    // Mostly line-structured traffic with a random indentation walk
    task automatic gen_random_lines(int count);
        int pick;
        int step;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < 33) begin
                push_tok(TYPE_W'($urandom), TAG_W'($urandom), 1'b0, IN_WIDTH_W'($urandom));
            end else if (pick < 39) begin
                push_tok(pick[0] ? cfg_model.newline_type : TYPE_W'($urandom),
                         TAG_W'($urandom), 1'b1, IN_WIDTH_W'($urandom));
            end else begin
                step = $urandom_range(0, 9);
                if (step < 4)
                    walk_width = (walk_width + $urandom_range(1, 6) > 255) ? 255
                                 : walk_width + $urandom_range(1, 6);
                else if (step >= 6 && step < 9)
                    walk_width = $urandom_range(0, walk_width);
                else if (step == 9)
                    walk_width = $urandom_range(0, 255);
                push_tok(cfg_model.newline_type, TAG_W'($urandom), 1'b0, walk_width[7:0]);
            end
        end
    endtask

    // Reset and stimulus phases
    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed tokens under the reset register values
        push_tok(16'hFFFF, 16'hFFFF, 1'b0, 8'hFF);
        push_tok(16'h0001, 16'h0000, 1'b0, 8'h00);
        push_tok(RST_NEWLINE_TYPE, 16'h1111, 1'b0, 8'd4);
        push_tok(RST_NEWLINE_TYPE, 16'h2222, 1'b0, 8'd8);
        push_tok(16'h0007, 16'hABCD, 1'b0, 8'd0);
        push_tok(RST_NEWLINE_TYPE, 16'h3333, 1'b0, 8'd8);
        // width between two levels
        push_tok(RST_NEWLINE_TYPE, 16'h4444, 1'b0, 8'd6);
        push_tok(RST_NEWLINE_TYPE, 16'h5555, 1'b0, 8'd255);
        push_tok(RST_NEWLINE_TYPE, 16'h6666, 1'b0, 8'd0);
        push_tok(RST_NEWLINE_TYPE, 16'h7777, 1'b0, 8'd0);
        push_tok(RST_NEWLINE_TYPE, 16'h8888, 1'b0, 8'd1);
        push_tok(RST_NEWLINE_TYPE, 16'h9999, 1'b0, 8'd2);
        push_tok(RST_NEWLINE_TYPE, 16'hAAAA, 1'b0, 8'd1);
        push_tok(16'h8000, 16'h5A5A, 1'b0, 8'hAA);
        push_tok(RST_NEWLINE_TYPE, 16'hBBBB, 1'b0, 8'd0);
        wait_drained();

        // Full stack, refused pushes and the first end token flush
        sender_gaps_on     = 1'b0;
        receiver_stalls_on = 1'b1;
        set_types(16'hFFFF, 16'h0000, 16'h8001);
        push_full_stack(0);
        push_tok(16'hFFFF, TAG_W'($urandom), 1'b0, 8'd255);
        push_tok(16'hFFFF, TAG_W'($urandom), 1'b0, 8'd254);
        push_tok(16'h0100, TAG_W'($urandom), 1'b0, 8'd3);
        // end token that also carries the newline type
        push_tok(16'hFFFF, TAG_W'($urandom), 1'b1, 8'd0);
        push_tok(16'h1234, TAG_W'($urandom), 1'b1, 8'd77);
        wait_drained();

        // Fill again after the end, then close every level with one newline
        sender_gaps_on = 1'b1;
        push_full_stack(0);
        push_tok(16'hFFFF, TAG_W'($urandom), 1'b0, 8'd0);
        push_tok(16'hFFFF, TAG_W'($urandom), 1'b0, 8'd5);
        walk_width = 5;
        wait_drained();

        // Random phases over a spread of register settings
        sender_gaps_on     = 1'b0;
        receiver_stalls_on = 1'b0;
        set_types(16'h0000, 16'hFFFF, 16'h0000);
        gen_random_lines(40);
        wait_drained();

        sender_gaps_on     = 1'b1;
        receiver_stalls_on = 1'b1;
        set_types(TYPE_W'($urandom), TYPE_W'($urandom), TYPE_W'($urandom));
        gen_random_lines(40);
        wait_drained();

        sender_gaps_on     = 1'b0;
        receiver_stalls_on = 1'b1;
        set_types(16'h5A5A, 16'hA5A5, 16'h00FF);
        gen_random_lines(35);
        wait_drained();

        sender_gaps_on     = 1'b1;
        receiver_stalls_on = 1'b0;
        set_types(TYPE_W'($urandom), 16'hFFFF, 16'hFFFF);
        gen_random_lines(35);
        wait_drained();

        sender_gaps_on     = 1'b1;
        receiver_stalls_on = 1'b1;
        set_types(TYPE_W'($urandom), TYPE_W'($urandom), TYPE_W'($urandom));
        gen_random_lines(40);
        wait_drained();
        repeat (16) @(posedge i_clk);

        if (mismatch_count == 0 && expected_tokens.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ----- indent_dedent_token_generator.f -----
src/idt_pkg.sv
src/idt_regs.sv
src/idt_ctrl.sv
src/idt_dpath.sv
src/indent_dedent_token_generator.sv
test/tb_top.sv
